[rtl/core/jvs_pkg.sv]
// ----------------------------------------------------------------------------
// jvs_pkg
// Shared types, character codes and literal tables for the value span scanner.
// ----------------------------------------------------------------------------
package jvs_pkg;

  localparam int OFF_W   = 17;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int TDATA_W = 40;

  typedef enum logic [3:0] {
    PH_WS         = 4'd0,
    PH_STRING     = 4'd1,
    PH_OBJECT     = 4'd2,
    PH_ARRAY      = 4'd3,
    PH_LITERAL    = 4'd4,
    PH_NUM_INT    = 4'd5,
    PH_NUM_FRAC   = 4'd6,
    PH_NUM_EXP    = 4'd7,
    PH_NUM_EXPDIG = 4'd8,
    PH_DONE       = 4'd9
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY  = 3'd0,
    KIND_NULL   = 3'd1,
    KIND_BOOL   = 3'd2,
    KIND_NUMBER = 3'd3,
    KIND_STRING = 3'd4,
    KIND_OBJECT = 3'd5,
    KIND_ARRAY  = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              bool_value;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  end_offset;
  } result_t;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // Expected character of literal k at index i ("true", "false", "null").
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (i)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (i)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (i)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

[rtl/core/jvs_in_stage.sv]
// ----------------------------------------------------------------------------
// jvs_in_stage
// Input register holding one byte transaction until the scan core takes it.
// ----------------------------------------------------------------------------
module jvs_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [jvs_pkg::BYTE_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tlast,
  input  logic                     advance,
  output logic                     in_vld,
  output logic [jvs_pkg::BYTE_W-1:0] in_byte,
  output logic                     in_fin
);

  assign s_axis_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_fin  <= s_axis_tlast;
    end
  end

endmodule

[rtl/core/jvs_scan_core.sv]
// ----------------------------------------------------------------------------
// jvs_scan_core
// Scan state and per-byte classification; one byte per step.
// ----------------------------------------------------------------------------
module jvs_scan_core #(
  parameter int MAX_BUFFER_BYTES = 65536,
  parameter int MAX_NESTING      = 255
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [jvs_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_fin,
  output logic                       res_valid,
  output jvs_pkg::result_t           res
);

  localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 2);
  localparam int DEP_W = $clog2(MAX_NESTING + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [DEP_W-1:0] DEP_MAX = DEP_W'(MAX_NESTING);
  localparam logic [DEP_W-1:0] DEP_ONE = DEP_W'(1);

  jvs_pkg::phase_t  phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] vstart, vstart_next;
  logic [DEP_W-1:0] depth, depth_next;
  logic             inq, inq_next;
  logic             pbs, pbs_next;
  logic [1:0]       lkind, lkind_next;
  logic [2:0]       lidx, lidx_next;

  logic             emit;
  jvs_pkg::result_t r;
  logic [1:0]       k;
  logic [2:0]       li;
  logic [2:0]       li_inc;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       b;
  logic             open_hit;
  logic             close_hit;

  function automatic jvs_pkg::result_t mk(input jvs_pkg::kind_t kd, input logic bv,
                                          input logic [POS_W-1:0] s,
                                          input logic [POS_W-1:0] e);
    jvs_pkg::result_t o;
    o.kind         = kd;
    o.bool_value   = bv;
    o.start_offset = jvs_pkg::OFF_W'(s);
    o.end_offset   = jvs_pkg::OFF_W'(e);
    return o;
  endfunction

  // Close the open value as if the buffer ended at length len.
  function automatic jvs_pkg::result_t finish(input jvs_pkg::phase_t ph,
                                              input logic [POS_W-1:0] vs,
                                              input logic bs,
                                              input logic [POS_W-1:0] len);
    jvs_pkg::result_t o;
    case (ph)
      jvs_pkg::PH_WS:      o = mk(jvs_pkg::KIND_EMPTY, 1'b0, '0, '0);
      jvs_pkg::PH_STRING:  o = mk(jvs_pkg::KIND_STRING, 1'b0, vs, bs ? len + 1'b1 : len);
      jvs_pkg::PH_OBJECT:  o = mk(jvs_pkg::KIND_OBJECT, 1'b0, vs, len + 1'b1);
      jvs_pkg::PH_ARRAY:   o = mk(jvs_pkg::KIND_ARRAY, 1'b0, vs, len + 1'b1);
      jvs_pkg::PH_LITERAL: o = mk(jvs_pkg::KIND_NULL, 1'b0, vs, vs);
      default:             o = mk(jvs_pkg::KIND_NUMBER, 1'b0, vs, len);
    endcase
    return o;
  endfunction

  assign b       = in_byte;
  assign pos_inc = pos + 1'b1;
  assign k       = (lkind == 2'd3) ? jvs_pkg::LIT_NULL : lkind;
  assign li      = (lidx > 3'd4) ? 3'd4 : lidx;
  assign li_inc  = li + 3'd1;

  always_comb begin
    phase_next  = phase;
    vstart_next = vstart;
    depth_next  = depth;
    inq_next    = inq;
    pbs_next    = pbs;
    lkind_next  = lkind;
    lidx_next   = lidx;
    emit        = 1'b0;
    r           = mk(jvs_pkg::KIND_EMPTY, 1'b0, '0, '0);
    open_hit    = 1'b0;
    close_hit   = 1'b0;

    if (phase != jvs_pkg::PH_DONE) begin
      if (pos >= POS_MAX) begin
        emit = 1'b1;
        r    = finish(phase, vstart, pbs, POS_MAX);
      end else begin
        case (phase)
          jvs_pkg::PH_WS: begin
            if (!jvs_pkg::is_ws(b)) begin
              vstart_next = pos;
              inq_next    = 1'b0;
              pbs_next    = 1'b0;
              if (b == jvs_pkg::CH_QUOTE) begin
                phase_next = jvs_pkg::PH_STRING;
              end else if (b == jvs_pkg::CH_LBRC) begin
                phase_next = jvs_pkg::PH_OBJECT;
                depth_next = DEP_ONE;
              end else if (b == jvs_pkg::CH_LBRK) begin
                phase_next = jvs_pkg::PH_ARRAY;
                depth_next = DEP_ONE;
              end else if (b == jvs_pkg::CH_T || b == jvs_pkg::CH_F ||
                           b == jvs_pkg::CH_N) begin
                lkind_next = (b == jvs_pkg::CH_T) ? jvs_pkg::LIT_TRUE :
                             (b == jvs_pkg::CH_F) ? jvs_pkg::LIT_FALSE :
                                                    jvs_pkg::LIT_NULL;
                lidx_next  = 3'd1;
                phase_next = jvs_pkg::PH_LITERAL;
              end else if (b == jvs_pkg::CH_MINUS || jvs_pkg::is_digit(b)) begin
                phase_next = jvs_pkg::PH_NUM_INT;
              end else begin
                emit = 1'b1;
                r    = mk(jvs_pkg::KIND_NULL, 1'b0, pos, pos);
              end
            end
          end
          jvs_pkg::PH_STRING: begin
            if (pbs) begin
              pbs_next = 1'b0;
            end else if (b == jvs_pkg::CH_QUOTE) begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_STRING, 1'b0, vstart, pos_inc);
            end else if (b == jvs_pkg::CH_BSL) begin
              pbs_next = 1'b1;
            end
          end
          jvs_pkg::PH_OBJECT, jvs_pkg::PH_ARRAY: begin
            if (b == jvs_pkg::CH_QUOTE && !pbs) begin
              inq_next = !inq;
            end
            pbs_next = (b == jvs_pkg::CH_BSL);
            if (phase == jvs_pkg::PH_OBJECT) begin
              open_hit  = (b == jvs_pkg::CH_LBRC);
              close_hit = (b == jvs_pkg::CH_RBRC);
            end else begin
              open_hit  = (b == jvs_pkg::CH_LBRK);
              close_hit = (b == jvs_pkg::CH_RBRK);
            end
            if (!inq_next) begin
              if (open_hit) begin
                if (depth < DEP_MAX) begin
                  depth_next = depth + 1'b1;
                end
              end else if (close_hit) begin
                if (depth != '0) begin
                  depth_next = depth - 1'b1;
                end
                if (depth <= DEP_ONE) begin
                  emit = 1'b1;
                  r    = mk((phase == jvs_pkg::PH_OBJECT) ? jvs_pkg::KIND_OBJECT :
                            jvs_pkg::KIND_ARRAY, 1'b0, vstart, pos_inc);
                end
              end
            end
          end
          jvs_pkg::PH_LITERAL: begin
            if (b != jvs_pkg::lit_char(k, li)) begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_NULL, 1'b0, vstart, vstart);
            end else begin
              lidx_next = li_inc;
              if (li_inc >= jvs_pkg::lit_len(k)) begin
                emit = 1'b1;
                if (k == jvs_pkg::LIT_NULL) begin
                  r = mk(jvs_pkg::KIND_NULL, 1'b0, vstart, pos_inc);
                end else begin
                  r = mk(jvs_pkg::KIND_BOOL, k == jvs_pkg::LIT_TRUE, vstart, pos_inc);
                end
              end
            end
          end
          jvs_pkg::PH_NUM_INT: begin
            if (b == jvs_pkg::CH_DOT) begin
              phase_next = jvs_pkg::PH_NUM_FRAC;
            end else if (b == jvs_pkg::CH_LE || b == jvs_pkg::CH_UE) begin
              phase_next = jvs_pkg::PH_NUM_EXP;
            end else if (!jvs_pkg::is_digit(b)) begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_NUMBER, 1'b0, vstart, pos);
            end
          end
          jvs_pkg::PH_NUM_FRAC: begin
            if (b == jvs_pkg::CH_LE || b == jvs_pkg::CH_UE) begin
              phase_next = jvs_pkg::PH_NUM_EXP;
            end else if (!jvs_pkg::is_digit(b)) begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_NUMBER, 1'b0, vstart, pos);
            end
          end
          jvs_pkg::PH_NUM_EXP: begin
            if (b == jvs_pkg::CH_PLUS || b == jvs_pkg::CH_MINUS || jvs_pkg::is_digit(b)) begin
              phase_next = jvs_pkg::PH_NUM_EXPDIG;
            end else begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_NUMBER, 1'b0, vstart, pos);
            end
          end
          jvs_pkg::PH_NUM_EXPDIG: begin
            if (!jvs_pkg::is_digit(b)) begin
              emit = 1'b1;
              r    = mk(jvs_pkg::KIND_NUMBER, 1'b0, vstart, pos);
            end
          end
          default: begin
          end
        endcase
        // final byte closes whatever is still open
        if (!emit && in_fin) begin
          emit = 1'b1;
          r    = finish(phase_next, vstart_next, pbs_next, pos_inc);
        end
      end
      if (emit) begin
        phase_next = jvs_pkg::PH_DONE;
      end
    end

    pos_next = (pos < POS_MAX) ? pos_inc : pos;

    if (in_fin) begin
      phase_next  = jvs_pkg::PH_WS;
      pos_next    = '0;
      vstart_next = '0;
      depth_next  = '0;
      inq_next    = 1'b0;
      pbs_next    = 1'b0;
      lkind_next  = 2'd0;
      lidx_next   = 3'd0;
    end
  end

  assign res_valid = emit;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= jvs_pkg::PH_WS;
      pos    <= '0;
      vstart <= '0;
      depth  <= '0;
      inq    <= 1'b0;
      pbs    <= 1'b0;
      lkind  <= 2'd0;
      lidx   <= 3'd0;
    end else if (step) begin
      phase  <= phase_next;
      pos    <= pos_next;
      vstart <= vstart_next;
      depth  <= depth_next;
      inq    <= inq_next;
      pbs    <= pbs_next;
      lkind  <= lkind_next;
      lidx   <= lidx_next;
    end
  end

endmodule

[rtl/core/jvs_out_stage.sv]
// ----------------------------------------------------------------------------
// jvs_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module jvs_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  jvs_pkg::result_t            res,
  output logic                        out_vld,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [jvs_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [jvs_pkg::KIND_W-1:0]  m_axis_tuser
);

  jvs_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = held.kind;
  assign m_axis_tdata  = {5'd0, held.end_offset, held.start_offset, held.bool_value};

endmodule

[rtl/core/json_value_span_scanner_top.sv]
// ----------------------------------------------------------------------------
// json_value_span_scanner_top
// Finds the first value in a byte stream and reports its kind and span.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, while the result side is not
// stalled, with tlast on the final byte of a buffer. Each byte passes an input
// register, then the scan state update, then a result register, which loads
// the result of the byte completing the value (or the final byte) and drives
// m_axis_tvalid. One result transaction is produced per buffer. A stalled result
// register holds the input side only once the input register is also full.
module json_value_span_scanner_top #(
  parameter int MAX_BUFFER_BYTES = 65536,
  parameter int MAX_NESTING      = 255
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [jvs_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tlast,   // final_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [jvs_pkg::TDATA_W-1:0] m_axis_tdata,   // [0] bool_value,
                                                      // [17:1] start_offset,
                                                      // [34:18] end_offset
  output logic [jvs_pkg::KIND_W-1:0]  m_axis_tuser    // [2:0] value_kind
);

  logic                       in_vld;
  logic [jvs_pkg::BYTE_W-1:0] in_byte;
  logic                       in_fin;
  logic                       out_vld;
  logic                       advance;
  logic                       res_valid;
  jvs_pkg::result_t           res;

  assign advance = in_vld && (!out_vld || m_axis_tready);

  jvs_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .advance       (advance),
    .in_vld        (in_vld),
    .in_byte       (in_byte),
    .in_fin        (in_fin)
  );

  jvs_scan_core #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
    .MAX_NESTING      (MAX_NESTING)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .in_fin    (in_fin),
    .res_valid (res_valid),
    .res       (res)
  );

  jvs_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && res_valid),
    .res           (res),
    .out_vld       (out_vld),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[rtl/core/jvs_checker.sv]
// ----------------------------------------------------------------------------
// jvs_checker
// Port-level checks for the value span scanner, bound to the top level.
// ----------------------------------------------------------------------------
module jvs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [jvs_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [jvs_pkg::KIND_W-1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= jvs_pkg::KIND_ARRAY)
    else $error("value kind out of range");

  a_bool: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == jvs_pkg::KIND_BOOL)
    else $error("bool value set on a non-bool result");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == jvs_pkg::KIND_EMPTY |->
      m_axis_tdata[34:1] == 34'd0)
    else $error("empty result with nonzero span");

endmodule

bind json_value_span_scanner_top jvs_checker u_jvs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON value span scanner.
// ----------------------------------------------------------------------------
// Streams text buffers into the scanner one byte per transaction, with tlast
// on the final byte. A scoreboard class keeps its own model of the scan and
// predicts the kind, bool flag and span of the first value of every buffer.
// Each result transaction is checked against the oldest prediction.
// The run has three parts:
//   - directed buffers: blank-only input, escapes, unterminated values,
//     literals, numbers and unknown bytes
//   - random buffers with idle bursts on both sides and one long output stall
//   - a tail of random buffers with no idling
// ----------------------------------------------------------------------------
module tb_top;
  import jvs_pkg::*;

  localparam int MAX_BYTES    = 65536;
  localparam int MAX_DEPTH    = 255;
  localparam int RANDOM_BYTES = 580;
  localparam int CALM_TAIL    = 120;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 800000;

  class span_scoreboard;
    result_t     spans[$];
    phase_t      phase;
    logic [16:0] pos;
    logic [16:0] start;
    logic [7:0]  depth;
    logic        quoted;
    logic        escaped;
    logic [1:0]  lit_sel;
    logic [2:0]  lit_idx;
    int          bytes_seen;
    int          buffers_seen;
    int          checked;
    int          errors;
    int          kind_hits[8];

    function new();
      rewind();
    endfunction

    function void rewind();
      phase   = PH_WS;
      pos     = '0;
      start   = '0;
      depth   = '0;
      quoted  = 1'b0;
      escaped = 1'b0;
      lit_sel = '0;
      lit_idx = '0;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function bit is_num(logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
    endfunction

    function string lit_word(logic [1:0] k);
      case (k)
        LIT_TRUE:  return "true";
        LIT_FALSE: return "false";
        default:   return "null";
      endcase
    endfunction

    function bit settle(kind_t k, logic bv, logic [16:0] s, logic [16:0] e,
                        output result_t r);
      r.kind         = k;
      r.bool_value   = bv;
      r.start_offset = s;
      r.end_offset   = e;
      phase          = PH_DONE;
      return 1'b1;
    endfunction

    function bit close_at_end(logic [16:0] len, output result_t r);
      case (phase)
        PH_WS:      return settle(KIND_EMPTY, 1'b0, '0, '0, r);
        PH_STRING:  return settle(KIND_STRING, 1'b0, start, escaped ? len + 17'd1 : len, r);
        PH_OBJECT:  return settle(KIND_OBJECT, 1'b0, start, len + 17'd1, r);
        PH_ARRAY:   return settle(KIND_ARRAY, 1'b0, start, len + 17'd1, r);
        PH_LITERAL: return settle(KIND_NULL, 1'b0, start, start, r);
        PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP, PH_NUM_EXPDIG:
          return settle(KIND_NUMBER, 1'b0, start, len, r);
        default:    return 1'b0;
      endcase
    endfunction

    function bit bracket_step(logic [7:0] b, logic [7:0] open_c, logic [7:0] close_c,
                              kind_t k, output result_t r);
      if (b == CH_QUOTE && !escaped) quoted = !quoted;
      escaped = (b == CH_BSL);
      if (!quoted) begin
        if (b == open_c) begin
          if (depth < 8'(MAX_DEPTH)) depth++;
        end else if (b == close_c) begin
          if (depth > 0) depth--;
          if (depth == 0) return settle(k, 1'b0, start, pos + 17'd1, r);
        end
      end
      return 1'b0;
    endfunction

    function bit scan_step(logic [7:0] b, output result_t r);
      string word;
      case (phase)
        PH_WS: begin
          if (is_blank(b)) return 1'b0;
          start   = pos;
          quoted  = 1'b0;
          escaped = 1'b0;
          if (b == CH_QUOTE) begin
            phase = PH_STRING;
          end else if (b == CH_LBRC) begin
            phase = PH_OBJECT;
            depth = 8'd1;
          end else if (b == CH_LBRK) begin
            phase = PH_ARRAY;
            depth = 8'd1;
          end else if (b == CH_T || b == CH_F || b == CH_N) begin
            lit_sel = (b == CH_T) ? LIT_TRUE : (b == CH_F) ? LIT_FALSE : LIT_NULL;
            lit_idx = 3'd1;
            phase   = PH_LITERAL;
          end else if (b == CH_MINUS || is_num(b)) begin
            phase = PH_NUM_INT;
          end else begin
            return settle(KIND_NULL, 1'b0, pos, pos, r);
          end
          return 1'b0;
        end
        PH_STRING: begin
          if (escaped) begin
            escaped = 1'b0;
            return 1'b0;
          end
          if (b == CH_QUOTE) return settle(KIND_STRING, 1'b0, start, pos + 17'd1, r);
          if (b == CH_BSL) escaped = 1'b1;
          return 1'b0;
        end
        PH_OBJECT: return bracket_step(b, CH_LBRC, CH_RBRC, KIND_OBJECT, r);
        PH_ARRAY:  return bracket_step(b, CH_LBRK, CH_RBRK, KIND_ARRAY, r);
        PH_LITERAL: begin
          word = lit_word(lit_sel);
          if (b != word[lit_idx]) return settle(KIND_NULL, 1'b0, start, start, r);
          lit_idx++;
          if (lit_idx >= word.len()) begin
            if (lit_sel == LIT_NULL) return settle(KIND_NULL, 1'b0, start, pos + 17'd1, r);
            return settle(KIND_BOOL, lit_sel == LIT_TRUE, start, pos + 17'd1, r);
          end
          return 1'b0;
        end
        PH_NUM_INT: begin
          if (is_num(b)) return 1'b0;
          if (b == CH_DOT) begin
            phase = PH_NUM_FRAC;
            return 1'b0;
          end
          if (b == CH_LE || b == CH_UE) begin
            phase = PH_NUM_EXP;
            return 1'b0;
          end
          return settle(KIND_NUMBER, 1'b0, start, pos, r);
        end
        PH_NUM_FRAC: begin
          if (is_num(b)) return 1'b0;
          if (b == CH_LE || b == CH_UE) begin
            phase = PH_NUM_EXP;
            return 1'b0;
          end
          return settle(KIND_NUMBER, 1'b0, start, pos, r);
        end
        PH_NUM_EXP: begin
          if (b == CH_PLUS || b == CH_MINUS || is_num(b)) begin
            phase = PH_NUM_EXPDIG;
            return 1'b0;
          end
          return settle(KIND_NUMBER, 1'b0, start, pos, r);
        end
        PH_NUM_EXPDIG: begin
          if (is_num(b)) return 1'b0;
          return settle(KIND_NUMBER, 1'b0, start, pos, r);
        end
        default: return 1'b0;
      endcase
    endfunction

    // one accepted input transaction
    function void take_byte(logic [7:0] b, logic last);
      result_t r;
      bit      hit;
      hit = 1'b0;
      if (phase != PH_DONE) begin
        if (pos == 17'(MAX_BYTES)) begin
          hit = close_at_end(17'(MAX_BYTES), r);
        end else begin
          hit = scan_step(b, r);
          if (!hit && last) hit = close_at_end(pos + 17'd1, r);
        end
      end
      if (hit) spans.push_back(r);
      if (pos != 17'(MAX_BYTES)) pos++;
      bytes_seen++;
      if (last) begin
        buffers_seen++;
        rewind();
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("tb_top: mismatch: %s", msg);
    endfunction

    // one accepted result transaction
    function void check_span(logic [2:0] kind, logic bv, logic [16:0] s, logic [16:0] e);
      result_t want;
      checked++;
      if (spans.size() == 0) begin
        note_error($sformatf("unexpected result kind %0d bool %0d span %0d..%0d",
                             kind, bv, s, e));
        return;
      end
      want = spans.pop_front();
      if (want.kind !== kind || want.bool_value !== bv ||
          want.start_offset !== s || want.end_offset !== e) begin
        note_error($sformatf("result %0d: want kind %0d bool %0d span %0d..%0d, got kind %0d bool %0d span %0d..%0d",
                             checked, want.kind, want.bool_value, want.start_offset,
                             want.end_offset, kind, bv, s, e));
      end else begin
        kind_hits[kind]++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]  m_axis_tuser;

  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         stall_left = 0;
  int         cycles = 0;
  logic [7:0] text_q[$];

  span_scoreboard sb = new();

  json_value_span_scanner_top #(
    .MAX_BUFFER_BYTES (MAX_BYTES),
    .MAX_NESTING      (MAX_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_span(m_axis_tuser, m_axis_tdata[0], m_axis_tdata[17:1], m_axis_tdata[34:18]);
  end

  // result side: short random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      stall_left    <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_buffer();
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 11))
      0:       return CH_BSL;
      1:       return CH_QUOTE;
      2:       return CH_LBRC;
      3:       return CH_RBRC;
      4:       return CH_LBRK;
      5:       return CH_RBRK;
      6, 7:    return 8'($urandom_range(8'h61, 8'h7A));
      8:       return 8'($urandom_range(CH_0, CH_9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_quoted(bit closed);
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) text_q.push_back(pick_text_byte());
    if (closed) text_q.push_back(CH_QUOTE);
  endtask

  task automatic add_nested(logic [7:0] open_c, logic [7:0] close_c);
    int open_count;
    open_count = 1;
    text_q.push_back(open_c);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 7))
        0: begin
          text_q.push_back(open_c);
          open_count++;
        end
        1: begin
          if (open_count > 1) begin
            text_q.push_back(close_c);
            open_count--;
          end
        end
        2, 3:    add_quoted($urandom_range(0, 3) != 0);
        4:       text_q.push_back(CH_BSL);
        default: text_q.push_back(pick_text_byte());
      endcase
    end
    if ($urandom_range(0, 4) != 0) repeat (open_count) text_q.push_back(close_c);
  endtask

  task automatic add_number();
    bit negative;
    negative = $urandom_range(0, 1);
    if (negative) text_q.push_back(CH_MINUS);
    repeat ($urandom_range(negative ? 0 : 1, 3)) text_q.push_back(8'($urandom_range(CH_0, CH_9)));
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_DOT);
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(CH_0, CH_9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
      case ($urandom_range(0, 2))
        0:       text_q.push_back(CH_PLUS);
        1:       text_q.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(CH_0, CH_9)));
    end
  endtask

  task automatic add_literal();
    string word;
    int    cut;
    case ($urandom_range(0, 2))
      0:       word = "true";
      1:       word = "false";
      default: word = "null";
    endcase
    cut = word.len();
    if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, word.len() - 1);
    for (int i = 0; i < cut; i++) text_q.push_back(word[i]);
    if ($urandom_range(0, 4) == 0) text_q[text_q.size() - 1] = 8'($urandom_range(0, 255));
  endtask

  task automatic build_buffer();
    int cut;
    text_q.delete();
    repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
    case ($urandom_range(0, 11))
      0, 1:    add_quoted($urandom_range(0, 3) != 0);
      2, 3:    add_nested(CH_LBRC, CH_RBRC);
      4, 5:    add_nested(CH_LBRK, CH_RBRK);
      6, 7:    add_literal();
      8, 9:    add_number();
      10:      text_q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    if (text_q.size() == 0) text_q.push_back(pick_blank());
    if (text_q.size() > 1 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endtask

  initial begin
    int rand_bytes;
    int picked;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text(" \t\015\n");
    send_text("\"ab\\\"c\"x");
    send_text("\"abc");
    send_text("  \"ab\\");
    send_text("{\"k\":{\"v\":\"}\"},[]} ");
    send_text("{\"a\\\"}\"");
    send_text("[1,[2],\"]\",{]");
    send_text("\t[{}");
    send_text("true");
    send_text("false,");
    send_text("null");
    send_text("tru");
    send_text("fxlse");
    send_text("nulL");
    send_text("-12.5e+3 ");
    send_text("0");
    send_text("1e");
    send_text("7E9,");
    send_text("-");
    send_text("3.x");
    send_text("1 2 3");
    send_text("{");
    text_q = '{8'h00};
    send_buffer();
    text_q = '{CH_SPACE, 8'hFF, CH_LBRC};
    send_buffer();

    rand_bytes = 0;
    picked     = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      if (rand_bytes >= RANDOM_BYTES - CALM_TAIL) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end else if (picked == 25) begin
        hold_req++;
        src_gaps = 1'b0;
      end else if (picked < 25 || picked > 45) begin
        src_gaps  = ($urandom_range(0, 3) != 0);
        sink_gaps = ($urandom_range(0, 3) != 0);
      end
      build_buffer();
      send_buffer();
      rand_bytes += text_q.size();
      picked++;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.spans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb_top: %0d bytes in %0d buffers, %0d results checked, %0d mismatches",
             sb.bytes_seen, sb.buffers_seen, sb.checked, sb.errors);
    $display("tb_top: empty %0d null %0d bool %0d number %0d string %0d object %0d array %0d",
             sb.kind_hits[KIND_EMPTY], sb.kind_hits[KIND_NULL], sb.kind_hits[KIND_BOOL],
             sb.kind_hits[KIND_NUMBER], sb.kind_hits[KIND_STRING], sb.kind_hits[KIND_OBJECT],
             sb.kind_hits[KIND_ARRAY]);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
